// ----- hw/rtl/rcjdm_pkg.sv -----
`default_nettype none

package rcjdm_pkg;

  // Register map, indexed by paddr[3:2].
  localparam logic [1:0] REG_MOTOR_IDLE     = 2'd0;
  localparam logic [1:0] REG_STICK_DEADBAND = 2'd1;
  localparam logic [1:0] REG_SPEED_PERCENT  = 2'd2;
  localparam logic [1:0] REG_TURN_PERCENT   = 2'd3;

  localparam int unsigned CFG_W = 7;

  localparam logic [CFG_W-1:0] IDLE_RST     = 7'd75;
  localparam logic [CFG_W-1:0] DEADBAND_RST = 7'd20;
  localparam logic [CFG_W-1:0] SPEED_RST    = 7'd60;
  localparam logic [CFG_W-1:0] TURN_RST     = 7'd80;
  localparam logic [CFG_W-1:0] PCT_MIN      = 7'd20;
  localparam logic [CFG_W-1:0] PCT_MAX      = 7'd100;

  // Stick mapping: pulse 2012 maps to +255 and 989 to -255, centre to 0.
  localparam logic signed [13:0] PULSE_TOP = 14'sd2012;
  localparam logic signed [11:0] AXIS_OFS  = 12'sd255;

  // Reciprocal constants for division by 1023, 100 and 255.
  localparam logic [10:0] RECIP_1023 = 11'd1025;   // / 2^20
  localparam logic [13:0] RECIP_100  = 14'd10485;  // / 2^20
  localparam logic [16:0] RECIP_255  = 17'd65793;  // / 2^24

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_e;

  // Saturate a written value to lo..hi.
  function automatic logic [CFG_W-1:0] sat_cfg(input logic [CFG_W-1:0] v,
                                               input logic [CFG_W-1:0] lo,
                                               input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rc_joystick_differential_drive_mixer_core.sv -----
`default_nettype none

// Arcade-drive mixer for two RC stick pulse widths.
// An input item carries the throttle (pulse_x_i) and turn (pulse_y_i) pulse
// widths in microseconds; each result item gives, per wheel, a clamped signed
// speed, a direction code and a PWM duty.
// Both channels use valid and stall: an item moves at a rising edge where
// valid is high and stall is low.
// The datapath is a 14-stage pipeline. When nothing stalls, one item can be
// taken every cycle, so throughput is one item per clock. The depth follows
// from the chain of constant divisions (by 1023, 100 and 255), each done as a
// reciprocal multiply in one stage and a remainder correction in the next.
// When the receiver stalls, the output item holds and empty stages ahead of it
// keep filling; the input stalls only once every stage holds an item.
// Reset clears all stage valid bits and loads the configuration registers with
// idle 75, deadband 20, speed 60 % and turn 80 %. Configuration is written
// over the APB-style port and saturates to each register's range; it is read
// live by the pipeline, so it should be changed only while the block is empty.
module rc_joystick_differential_drive_mixer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [11:0] pulse_x_i,
  input  wire logic [11:0] pulse_y_i,
  // Output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [8:0] left_speed_o,
  output logic [1:0]       left_direction_o,
  output logic [7:0]       left_duty_o,
  output logic signed [8:0] right_speed_o,
  output logic [1:0]       right_direction_o,
  output logic [7:0]       right_duty_o,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rcjdm_pkg::*;

  localparam int unsigned NSTG = 14;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] motor_idle_q, stick_deadband_q, speed_percent_q, turn_percent_q;
  logic [CFG_W-1:0] wr_val;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_val = pwdata[CFG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_idle_q     <= IDLE_RST;
      stick_deadband_q <= DEADBAND_RST;
      speed_percent_q  <= SPEED_RST;
      turn_percent_q   <= TURN_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_MOTOR_IDLE:     motor_idle_q     <= sat_cfg(wr_val, 7'd0, PCT_MAX);
        REG_STICK_DEADBAND: stick_deadband_q <= sat_cfg(wr_val, 7'd0, PCT_MAX);
        REG_SPEED_PERCENT:  speed_percent_q  <= sat_cfg(wr_val, PCT_MIN, PCT_MAX);
        REG_TURN_PERCENT:   turn_percent_q   <= sat_cfg(wr_val, PCT_MIN, PCT_MAX);
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_MOTOR_IDLE:     prdata[CFG_W-1:0] = motor_idle_q;
      REG_STICK_DEADBAND: prdata[CFG_W-1:0] = stick_deadband_q;
      REG_SPEED_PERCENT:  prdata[CFG_W-1:0] = speed_percent_q;
      REG_TURN_PERCENT:   prdata[CFG_W-1:0] = turn_percent_q;
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. A stage may load when it is empty or when the stage
  // after it loads too, so bubbles are squeezed out under a stall.
  // ---------------------------------------------------------------------------
  logic [NSTG:1] vld_q;
  logic [NSTG:1] en;

  always_comb begin
    en[NSTG] = !vld_q[NSTG] || !out_stall_i;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = vld_q[NSTG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) vld_q[1] <= in_valid_i;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: offset from the top of the span, magnitude times 510.
  // Lane 0 is the throttle axis, lane 1 the turn axis.
  // ---------------------------------------------------------------------------
  logic [11:0]        pulse [2];
  logic signed [13:0] ofs_d [2];
  logic [11:0]        ofs_mag [2];
  logic [20:0]        x1_d [2];
  logic               n1_d [2];
  logic [20:0]        x1_q [2];
  logic               n1_q [2];

  assign pulse[0] = pulse_x_i;
  assign pulse[1] = pulse_y_i;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      ofs_d[i]   = $signed({2'b00, pulse[i]}) - PULSE_TOP;
      n1_d[i]    = ofs_d[i][13];
      ofs_mag[i] = n1_d[i] ? 12'(-ofs_d[i]) : ofs_d[i][11:0];
      x1_d[i]    = {ofs_mag[i], 9'd0} - {8'd0, ofs_mag[i], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      x1_q <= x1_d;
      n1_q <= n1_d;
    end
  end

  // Stage 2: quotient estimate for / 1023, exact or one low.
  logic [30:0] e2_d [2];
  logic [20:0] x2_q [2];
  logic [10:0] q2_q [2];
  logic        n2_q [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      e2_d[i] = 31'(x1_q[i]) * 31'(RECIP_1023);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      x2_q <= x1_q;
      n2_q <= n1_q;
      for (int i = 0; i < 2; i++) q2_q[i] <= e2_d[i][30:20];
    end
  end

  // Stage 3: remainder correction and sign.
  logic [20:0]        r3_d [2];
  logic [10:0]        q3_d [2];
  logic signed [11:0] q3_q [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      r3_d[i] = x2_q[i] - ({q2_q[i], 10'd0} - {10'd0, q2_q[i]});
      q3_d[i] = q2_q[i] + 11'(r3_d[i] >= 21'd1023);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int i = 0; i < 2; i++) begin
        q3_q[i] <= n2_q[i] ? -$signed({1'b0, q3_d[i]}) : $signed({1'b0, q3_d[i]});
      end
    end
  end

  // Stage 4: add the 255 offset and apply the deadband.
  logic signed [11:0] m4_d [2];
  logic [10:0]        mag4_d [2];
  logic signed [11:0] j4_q [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      m4_d[i]   = q3_q[i] + AXIS_OFS;
      mag4_d[i] = m4_d[i][11] ? 11'(-m4_d[i]) : m4_d[i][10:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int i = 0; i < 2; i++) begin
        j4_q[i] <= (mag4_d[i] < {4'd0, stick_deadband_q}) ? 12'sd0 : m4_d[i];
      end
    end
  end

  // Stage 5: turn magnitude times turn percent.
  logic [10:0]        ty5_mag;
  logic [17:0]        tp5_d;
  logic signed [11:0] jx5_q;
  logic [16:0]        tp5_q;
  logic               tn5_q;

  assign ty5_mag = j4_q[1][11] ? 11'(-j4_q[1]) : j4_q[1][10:0];
  assign tp5_d   = 18'(ty5_mag) * 18'(turn_percent_q);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      jx5_q <= j4_q[0];
      tp5_q <= tp5_d[16:0];
      tn5_q <= j4_q[1][11];
    end
  end

  // Stage 6: quotient estimate for / 100.
  logic [31:0]        e6_d;
  logic signed [11:0] jx6_q;
  logic [16:0]        tp6_q;
  logic [10:0]        tq6_q;
  logic               tn6_q;

  assign e6_d = 32'(tp5_q) * 32'(RECIP_100);

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      jx6_q <= jx5_q;
      tp6_q <= tp5_q;
      tq6_q <= e6_d[30:20];
      tn6_q <= tn5_q;
    end
  end

  // Stage 7: correction, giving the scaled turn value.
  logic [17:0]        tm7_d;
  logic [16:0]        tr7_d;
  logic [10:0]        tq7_d;
  logic signed [11:0] jx7_q;
  logic signed [11:0] jy7_q;

  assign tm7_d = 18'(tq6_q) * 18'd100;
  assign tr7_d = tp6_q - tm7_d[16:0];
  assign tq7_d = tq6_q + 11'(tr7_d >= 17'd100);

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      jx7_q <= jx6_q;
      jy7_q <= tn6_q ? -$signed({1'b0, tq7_d}) : $signed({1'b0, tq7_d});
    end
  end

  // Stage 8: arcade mixing. Zero throttle spins in place.
  logic signed [12:0] mx8, my8;
  logic signed [12:0] ml8_d, mr8_d;
  logic signed [12:0] w8_q [2];

  always_comb begin
    mx8   = 13'(jx7_q);
    my8   = 13'(jy7_q);
    ml8_d = mx8;
    mr8_d = mx8;
    if (my8 > 13'sd0) begin
      if (mx8 > 13'sd0) begin
        mr8_d = mx8 - my8;
      end else if (mx8 < 13'sd0) begin
        mr8_d = mx8 + my8;
      end else begin
        ml8_d = my8;
        mr8_d = -my8;
      end
    end else if (my8 < 13'sd0) begin
      if (mx8 > 13'sd0) begin
        ml8_d = mx8 + my8;
      end else if (mx8 < 13'sd0) begin
        ml8_d = mx8 - my8;
      end else begin
        ml8_d = my8;
        mr8_d = -my8;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      w8_q[0] <= ml8_d;
      w8_q[1] <= mr8_d;
    end
  end

  // From here lane 0 is the left wheel and lane 1 the right wheel.
  // Stage 9: wheel magnitude times speed percent.
  logic [11:0] wm9_d [2];
  logic [18:0] wp9_d [2];
  logic [17:0] wp9_q [2];
  logic        wn9_q [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      wm9_d[i] = w8_q[i][12] ? 12'(-w8_q[i]) : w8_q[i][11:0];
      wp9_d[i] = 19'(wm9_d[i]) * 19'(speed_percent_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      for (int i = 0; i < 2; i++) begin
        wp9_q[i] <= wp9_d[i][17:0];
        wn9_q[i] <= w8_q[i][12];
      end
    end
  end

  // Stage 10: quotient estimate for / 100.
  logic [31:0] e10_d [2];
  logic [17:0] wp10_q [2];
  logic [11:0] wq10_q [2];
  logic        wn10_q [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      e10_d[i] = 32'(wp9_q[i]) * 32'(RECIP_100);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      wp10_q <= wp9_q;
      wn10_q <= wn9_q;
      for (int i = 0; i < 2; i++) wq10_q[i] <= e10_d[i][31:20];
    end
  end

  // Stage 11: correction and clamp of the magnitude to 255.
  logic [18:0] wm11_d [2];
  logic [17:0] wr11_d [2];
  logic [11:0] wq11_d [2];
  logic [7:0]  a11_q [2];
  logic        n11_q [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      wm11_d[i] = 19'(wq10_q[i]) * 19'd100;
      wr11_d[i] = wp10_q[i] - wm11_d[i][17:0];
      wq11_d[i] = wq10_q[i] + 12'(wr11_d[i] >= 18'd100);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[11]) begin
      n11_q <= wn10_q;
      for (int i = 0; i < 2; i++) begin
        a11_q[i] <= (wq11_d[i] > 12'd255) ? 8'd255 : wq11_d[i][7:0];
      end
    end
  end

  // Stage 12: signed speed, direction, and magnitude times (255 - idle).
  logic [7:0]        idle_span;
  logic [15:0]       t12_d [2];
  dir_e              dir12_d [2];
  logic signed [8:0] sp12_q [2];
  dir_e              dir12_q [2];
  logic [15:0]       t12_q [2];

  assign idle_span = 8'd255 - 8'(motor_idle_q);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      t12_d[i] = 16'(a11_q[i]) * 16'(idle_span);
      if (a11_q[i] == 8'd0) begin
        dir12_d[i] = DIR_STOP;
      end else if (n11_q[i]) begin
        dir12_d[i] = DIR_REV;
      end else begin
        dir12_d[i] = DIR_FWD;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[12]) begin
      t12_q   <= t12_d;
      dir12_q <= dir12_d;
      for (int i = 0; i < 2; i++) begin
        sp12_q[i] <= n11_q[i] ? -$signed({1'b0, a11_q[i]}) : $signed({1'b0, a11_q[i]});
      end
    end
  end

  // Stage 13: quotient estimate for / 255.
  logic [32:0]       e13_d [2];
  logic signed [8:0] sp13_q [2];
  dir_e              dir13_q [2];
  logic [15:0]       t13_q [2];
  logic [7:0]        q13_q [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      e13_d[i] = 33'(t12_q[i]) * 33'(RECIP_255);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[13]) begin
      sp13_q  <= sp12_q;
      dir13_q <= dir12_q;
      t13_q   <= t12_q;
      for (int i = 0; i < 2; i++) q13_q[i] <= e13_d[i][31:24];
    end
  end

  // Stage 14: correction and idle offset; a duty not above idle gives zero.
  logic [15:0]       m14_d [2];
  logic [15:0]       r14_d [2];
  logic [7:0]        q14_d [2];
  logic signed [8:0] sp14_q [2];
  dir_e              dir14_q [2];
  logic [7:0]        duty14_q [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      m14_d[i] = {q13_q[i], 8'd0} - {8'd0, q13_q[i]};
      r14_d[i] = t13_q[i] - m14_d[i];
      q14_d[i] = q13_q[i] + 8'(r14_d[i] >= 16'd255);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[14]) begin
      sp14_q  <= sp13_q;
      dir14_q <= dir13_q;
      for (int i = 0; i < 2; i++) begin
        duty14_q[i] <= (q14_d[i] == 8'd0) ? 8'd0 : q14_d[i] + 8'(motor_idle_q);
      end
    end
  end

  assign left_speed_o      = sp14_q[0];
  assign left_direction_o  = dir14_q[0];
  assign left_duty_o       = duty14_q[0];
  assign right_speed_o     = sp14_q[1];
  assign right_direction_o = dir14_q[1];
  assign right_duty_o      = duty14_q[1];

endmodule

`default_nettype wire
